/* design/rcf_pkg.sv */
// Shared types and constants of the record continuation framer.
// No dependencies; all design files but the two interfaces refer to it by scoped names.
`timescale 1ns / 1ps

package rcf_pkg;

    // Command codes of an input item
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_END   = 2'd2,
        CMD_SLICE = 2'd3
    } cmd_t;

    // Configuration register indexes
    localparam logic CFG_MAX_RECORD  = 1'b0;
    localparam logic CFG_CONTINUE_ID = 1'b1;

    localparam logic [15:0] MAX_RECORD_RESET  = 16'd8224;
    localparam logic [15:0] CONTINUE_ID_RESET = 16'd60;

    localparam logic [3:0] UNIT_MAX_BYTES = 4'd8;

    // Job queue between the front and back ends
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    // Emission job produced by one input item
    typedef struct packed {
        logic        has_patch;
        logic [31:0] patch_offset;
        logic [15:0] patch_value;
        logic        has_header;
        logic [15:0] hdr_id;
        logic [15:0] hdr_size;
        logic [3:0]  nbytes;
        logic [63:0] data;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_push_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_stat_t;

endpackage

/* design/rcf_cmd_if.sv */
// Command channel interface: valid/ready plus the fields of one input item.
// No dependencies.
`timescale 1ns / 1ps

interface rcf_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] record_id;
    logic [31:0] predicted_size;
    logic [63:0] unit_data;
    logic [3:0]  unit_bytes;
    logic [15:0] slice_size;

    modport source (
        output valid, cmd, record_id, predicted_size, unit_data, unit_bytes, slice_size,
        input  ready
    );
    modport sink (
        input  valid, cmd, record_id, predicted_size, unit_data, unit_bytes, slice_size,
        output ready
    );
endinterface

/* design/rcf_res_if.sv */
// Result channel interface: valid/ready plus the fields of one result item.
// No dependencies.
`timescale 1ns / 1ps

interface rcf_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  out_byte;
    logic [31:0] patch_offset;
    logic [15:0] patch_value;
    logic        last;

    modport source (
        output valid, kind, out_byte, patch_offset, patch_value, last,
        input  ready
    );
    modport sink (
        input  valid, kind, out_byte, patch_offset, patch_value, last,
        output ready
    );
endinterface

/* design/record_continuation_framer_unit.sv */
// Record continuation framer, top level: front end, job queue and back end.
// Path of an item: queue entry, then the back end's job register, then the output register.
// The back end gives one result per cycle while the sink takes them; an item yields up to
// 13 results, and the byte-wide result register sets that rate.
// Reset (asynchronous, active low): framing state and registers to their reset values,
// queue empty, no result pending; no clearing pass.
`timescale 1ns / 1ps

module record_continuation_framer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    rcf_cmd_if.sink     items,
    rcf_res_if.source   results
);

    // The front end takes a command item whenever the queue has room.
    // It owns all of the framing state (record size, limits, slice count, stream
    // position) and reduces every item to a job: an optional size patch, an
    // optional four-byte header, then zero to eight unit bytes. Items that give
    // no result (slice size, end without patch, empty write) push nothing.
    rcf_pkg::job_push_t push;
    rcf_pkg::job_t      head;
    rcf_pkg::q_stat_t   q_stat;
    logic               pop;

    rcf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (items),
        .q_stat    (q_stat),
        .push      (push)
    );

    // Four-entry queue: lets commands run ahead while a long job drains.
    rcf_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .q_stat (q_stat)
    );

    // The back end walks each job one result a cycle and picks up the next job
    // in the same cycle as the last result of the current one, so there are no
    // bubbles between jobs while the sink keeps taking items.
    rcf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_stat  (q_stat),
        .pop     (pop),
        .results (results)
    );

endmodule

/* design/rcf_front.sv */
// Front end: takes command items, keeps the framing state, builds emission jobs.
// Depends on rcf_pkg and rcf_cmd_if.
`timescale 1ns / 1ps

module rcf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    rcf_cmd_if.sink             items,
    input  rcf_pkg::q_stat_t    q_stat,
    output rcf_pkg::job_push_t  push
);

    logic [15:0] max_record_size_reg, continue_id_reg;
    logic        in_record_reg, in_record_next;
    logic [15:0] current_size_reg, current_size_next;
    logic [15:0] current_limit_reg, current_limit_next;
    logic [15:0] continue_limit_reg, continue_limit_next;
    logic [15:0] slice_limit_reg, slice_limit_next;
    logic [15:0] slice_count_reg, slice_count_next;
    logic [31:0] pred_rem_reg, pred_rem_next;
    logic [15:0] header_size_reg, header_size_next;
    logic [31:0] size_field_pos_reg, size_field_pos_next;
    logic [31:0] stream_pos_reg, stream_pos_next;

    logic          accept;
    rcf_pkg::cmd_t cmd;
    logic [3:0]    len;
    logic          fit_over, slice_over, cont;
    logic [31:0]   pred_after;
    logic [15:0]   cont_hdr, start_hdr;
    logic [16:0]   slice_sum;
    logic [15:0]   slice_base;
    logic [3:0]    pos_step;
    rcf_pkg::job_t job;

    assign items.ready = !q_stat.full;
    assign accept      = items.valid && items.ready;
    assign cmd         = rcf_pkg::cmd_t'(items.cmd);
    assign len         = (items.unit_bytes > rcf_pkg::UNIT_MAX_BYTES)
                         ? rcf_pkg::UNIT_MAX_BYTES : items.unit_bytes;

    // continuation test of a write
    assign fit_over   = ({1'b0, current_size_reg} + {13'b0, len}) > {1'b0, current_limit_reg};
    assign slice_over = (slice_limit_reg != 16'd0) && (slice_count_reg == 16'd0) &&
                        (({1'b0, current_size_reg} + {1'b0, slice_limit_reg}) >
                         {1'b0, current_limit_reg});
    assign cont       = in_record_reg && (fit_over || slice_over);

    assign pred_after = pred_rem_reg - {16'b0, current_size_reg};
    assign cont_hdr   = (pred_after < {16'b0, continue_limit_reg})
                        ? pred_after[15:0] : continue_limit_reg;
    assign start_hdr  = (items.predicted_size < {16'b0, max_record_size_reg})
                        ? items.predicted_size[15:0] : max_record_size_reg;

    assign slice_base = cont ? 16'd0 : slice_count_reg;
    assign slice_sum  = {1'b0, slice_base} + {13'b0, len};

    always_comb
    begin
        in_record_next      = in_record_reg;
        current_size_next   = current_size_reg;
        current_limit_next  = current_limit_reg;
        continue_limit_next = continue_limit_reg;
        slice_limit_next    = slice_limit_reg;
        slice_count_next    = slice_count_reg;
        pred_rem_next       = pred_rem_reg;
        header_size_next    = header_size_reg;
        size_field_pos_next = size_field_pos_reg;
        pos_step            = 4'd0;

        job.has_patch    = 1'b0;
        job.patch_offset = size_field_pos_reg;
        job.patch_value  = current_size_reg;
        job.has_header   = 1'b0;
        job.hdr_id       = items.record_id;
        job.hdr_size     = start_hdr;
        job.nbytes       = 4'd0;
        job.data         = items.unit_data;

        unique case (cmd)
            rcf_pkg::CMD_START:
            begin
                continue_limit_next = max_record_size_reg;
                current_limit_next  = max_record_size_reg;
                pred_rem_next       = items.predicted_size;
                in_record_next      = 1'b1;
                size_field_pos_next = stream_pos_reg + 32'd2;
                header_size_next    = start_hdr;
                current_size_next   = 16'd0;
                slice_limit_next    = 16'd0;
                slice_count_next    = 16'd0;
                job.has_header      = 1'b1;
                pos_step            = 4'd4;
            end
            rcf_pkg::CMD_WRITE:
            begin
                job.nbytes = len;
                pos_step   = len;
                if (in_record_reg)
                begin
                    if (cont)
                    begin
                        job.has_patch       = (current_size_reg != header_size_reg);
                        job.has_header      = 1'b1;
                        job.hdr_id          = continue_id_reg;
                        job.hdr_size        = cont_hdr;
                        current_limit_next  = continue_limit_reg;
                        pred_rem_next       = pred_after;
                        header_size_next    = cont_hdr;
                        size_field_pos_next = stream_pos_reg + 32'd2;
                        pos_step            = len + 4'd4;
                        current_size_next   = {12'b0, len};
                    end
                    else
                    begin
                        current_size_next = current_size_reg + {12'b0, len};
                    end
                    if (slice_limit_reg != 16'd0)
                    begin
                        slice_count_next = (slice_sum >= {1'b0, slice_limit_reg})
                                           ? 16'd0 : slice_sum[15:0];
                    end
                    else if (cont)
                    begin
                        slice_count_next = 16'd0;
                    end
                end
            end
            rcf_pkg::CMD_END:
            begin
                if (in_record_reg)
                begin
                    job.has_patch  = (current_size_reg != header_size_reg);
                    in_record_next = 1'b0;
                end
            end
            rcf_pkg::CMD_SLICE:
            begin
                slice_limit_next = items.slice_size;
                slice_count_next = 16'd0;
            end
            default: ;
        endcase

        stream_pos_next = stream_pos_reg + {28'b0, pos_step};
    end

    assign push.valid = accept && (job.has_patch || job.has_header || (job.nbytes != 4'd0));
    assign push.job   = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_record_size_reg <= rcf_pkg::MAX_RECORD_RESET;
            continue_id_reg     <= rcf_pkg::CONTINUE_ID_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == rcf_pkg::CFG_MAX_RECORD)
                max_record_size_reg <= cfg_data;
            else if (cfg_index == rcf_pkg::CFG_CONTINUE_ID)
                continue_id_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_record_reg      <= 1'b0;
            current_size_reg   <= 16'd0;
            current_limit_reg  <= 16'd0;
            continue_limit_reg <= rcf_pkg::MAX_RECORD_RESET;
            slice_limit_reg    <= 16'd0;
            slice_count_reg    <= 16'd0;
            pred_rem_reg       <= 32'd0;
            header_size_reg    <= 16'd0;
            size_field_pos_reg <= 32'd0;
            stream_pos_reg     <= 32'd0;
        end
        else if (accept)
        begin
            in_record_reg      <= in_record_next;
            current_size_reg   <= current_size_next;
            current_limit_reg  <= current_limit_next;
            continue_limit_reg <= continue_limit_next;
            slice_limit_reg    <= slice_limit_next;
            slice_count_reg    <= slice_count_next;
            pred_rem_reg       <= pred_rem_next;
            header_size_reg    <= header_size_next;
            size_field_pos_reg <= size_field_pos_next;
            stream_pos_reg     <= stream_pos_next;
        end
    end

    // slice count always sits below an active slice size
    a_slice_count: assert property (@(posedge clk) disable iff (!rst_n)
        (slice_limit_reg != 16'd0) |-> (slice_count_reg < slice_limit_reg))
        else $error("slice count reached slice size");

    a_start_opens: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == rcf_pkg::CMD_START) |=> in_record_reg)
        else $error("start did not open a record");

endmodule

/* design/rcf_queue.sv */
// Short job queue in flip-flops between the front and back ends.
// Depends on rcf_pkg.
`timescale 1ns / 1ps

module rcf_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  rcf_pkg::job_push_t push,
    input  logic               pop,
    output rcf_pkg::job_t      head,
    output rcf_pkg::q_stat_t   q_stat
);

    rcf_pkg::job_t                  mem_reg [rcf_pkg::QDEPTH];
    logic [rcf_pkg::QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [rcf_pkg::QCOUNT_W-1:0]   count_reg, count_next;
    logic                           do_push, do_pop;

    assign q_stat.not_empty = (count_reg != '0);
    assign q_stat.full      = (count_reg == rcf_pkg::QCOUNT_W'(rcf_pkg::QDEPTH));
    assign head             = mem_reg[rd_ptr_reg];

    assign do_push = push.valid && !q_stat.full;
    assign do_pop  = pop && q_stat.not_empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + rcf_pkg::QCOUNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - rcf_pkg::QCOUNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + rcf_pkg::QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + rcf_pkg::QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push.job;
    end

    // the front end must hold off while the queue is full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !q_stat.full)
        else $error("job pushed into a full queue");

endmodule

/* design/rcf_back.sv */
// Back end: queued jobs to results in an output register, one per cycle unless stalled.
// Depends on rcf_pkg and rcf_res_if.
`timescale 1ns / 1ps

module rcf_back (
    input  logic              clk,
    input  logic              rst_n,
    input  rcf_pkg::job_t     head,
    input  rcf_pkg::q_stat_t  q_stat,
    output logic              pop,
    rcf_res_if.source         results
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PATCH = 4'b0010,
        ST_HDR   = 4'b0100,
        ST_DATA  = 4'b1000
    } state_t;

    state_t        state_reg, state_next, state_after, first_state;
    rcf_pkg::job_t job_reg;
    logic [1:0]    hdr_idx_reg, hdr_idx_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [63:0]   data_reg, data_next;

    logic          out_valid_reg;
    logic          out_kind_reg, out_last_reg;
    logic [7:0]    out_byte_reg;
    logic [31:0]   out_offset_reg;
    logic [15:0]   out_value_reg;

    logic          adv, produce, load, job_done;
    logic          res_kind;
    logic [7:0]    res_byte;
    logic [31:0]   res_offset;
    logic [15:0]   res_value;

    assign adv     = !out_valid_reg || results.ready;
    assign produce = adv && (state_reg != ST_IDLE);
    assign load    = q_stat.not_empty && ((state_reg == ST_IDLE) || (produce && job_done));
    assign pop     = load;

    always_comb
    begin
        if (head.has_patch)
            first_state = ST_PATCH;
        else if (head.has_header)
            first_state = ST_HDR;
        else
            first_state = ST_DATA;
    end

    // result of the current step
    always_comb
    begin
        res_kind     = 1'b0;
        res_byte     = 8'd0;
        res_offset   = 32'd0;
        res_value    = 16'd0;
        job_done     = 1'b0;
        state_after  = state_reg;
        hdr_idx_next = hdr_idx_reg;
        cnt_next     = cnt_reg;
        data_next    = data_reg;

        unique case (state_reg)
            ST_IDLE: ;
            ST_PATCH:
            begin
                res_kind   = 1'b1;
                res_offset = job_reg.patch_offset;
                res_value  = job_reg.patch_value;
                if (job_reg.has_header)
                    state_after = ST_HDR;
                else if (cnt_reg != 4'd0)
                    state_after = ST_DATA;
                else
                    job_done = 1'b1;
            end
            ST_HDR:
            begin
                case (hdr_idx_reg)
                    2'd0:    res_byte = job_reg.hdr_id[7:0];
                    2'd1:    res_byte = job_reg.hdr_id[15:8];
                    2'd2:    res_byte = job_reg.hdr_size[7:0];
                    default: res_byte = job_reg.hdr_size[15:8];
                endcase
                hdr_idx_next = hdr_idx_reg + 2'd1;
                if (hdr_idx_reg == 2'd3)
                begin
                    if (cnt_reg != 4'd0)
                        state_after = ST_DATA;
                    else
                        job_done = 1'b1;
                end
            end
            ST_DATA:
            begin
                res_byte  = data_reg[7:0];
                data_next = data_reg >> 8;
                cnt_next  = cnt_reg - 4'd1;
                if (cnt_reg == 4'd1)
                    job_done = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        if (load)
            state_next = first_state;
        else if (produce)
            state_next = job_done ? ST_IDLE : state_after;
        else
            state_next = state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (produce)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg     <= head;
            cnt_reg     <= head.nbytes;
            data_reg    <= head.data;
            hdr_idx_reg <= 2'd0;
        end
        else if (produce)
        begin
            cnt_reg     <= cnt_next;
            data_reg    <= data_next;
            hdr_idx_reg <= hdr_idx_next;
        end
        if (produce)
        begin
            out_kind_reg   <= res_kind;
            out_byte_reg   <= res_byte;
            out_offset_reg <= res_offset;
            out_value_reg  <= res_value;
            out_last_reg   <= job_done;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.kind         = out_kind_reg;
    assign results.out_byte     = out_byte_reg;
    assign results.patch_offset = out_offset_reg;
    assign results.patch_value  = out_value_reg;
    assign results.last         = out_last_reg;

    a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DATA) |-> (cnt_reg != 4'd0))
        else $error("data phase with no bytes left");

    a_patch_job: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PATCH) |-> job_reg.has_patch)
        else $error("patch phase for a job without a patch");

    a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !q_stat.not_empty) |=> (state_reg == ST_IDLE))
        else $error("job started with nothing queued");

endmodule

/* bench/tb.sv */
// Self-checking bench for record_continuation_framer_unit: command items in, framed stream out.
// Depends on rcf_pkg, rcf_cmd_if, rcf_res_if and the framer top level.
`timescale 1ns / 1ps

module tb;
    import rcf_pkg::*;

    // Generous: worst case is 13 results per item, each behind a random receiver stall.
    localparam int CYCLE_LIMIT  = 600000;
    // Items that emit nothing may still be in flight once the last result has gone.
    localparam int DRAIN_CYCLES = 12;

    // One command item as offered on the input channel
    typedef struct {
        cmd_t        cmd;
        logic [15:0] record_id;
        logic [31:0] predicted_size;
        logic [63:0] unit_data;
        logic [3:0]  unit_bytes;
        logic [15:0] slice_size;
    } cmd_item_t;

    // One output item: appended byte or size field patch
    typedef struct packed {
        logic        kind;
        logic [7:0]  out_byte;
        logic [31:0] patch_offset;
        logic [15:0] patch_value;
        logic        last;
    } out_item_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    rcf_cmd_if cmd_bus ();
    rcf_res_if res_bus ();

    record_continuation_framer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (cmd_bus),
        .results   (res_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Framer model: register copies and framing state
    // ------------------------------------------------------------------
    logic [15:0] reg_max_record;
    logic [15:0] reg_cont_id;
    bit          in_rec;
    logic [15:0] rec_size;      // payload bytes in the open record
    logic [15:0] rec_limit;
    logic [15:0] cont_limit;    // limit taken by continuation records
    logic [15:0] slice_len;
    logic [31:0] slice_fill;
    logic [31:0] pred_left;     // predicted remainder, wraps mod 2^32
    logic [15:0] hdr_size;      // value written into the size field
    logic [31:0] size_pos;      // stream offset of that size field
    logic [31:0] out_pos;       // bytes appended so far

    out_item_t   item_outputs[$];   // outputs of the item being framed
    out_item_t   due_outputs[$];    // outputs owed by the block, oldest first

    int          errors = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    bit          idle_on = 1'b0;
    int          hold_off = 0;      // long receiver stall, counted down by the sink

    function automatic void push_byte(input logic [7:0] b);
        out_item_t r;
        r = '{kind: 1'b0, out_byte: b, patch_offset: 32'd0, patch_value: 16'd0, last: 1'b0};
        item_outputs.push_back(r);
        out_pos = out_pos + 32'd1;
    endfunction

    // Size patch only when the payload differs from what the header claimed
    function automatic void close_size();
        out_item_t r;
        if (rec_size != hdr_size)
        begin
            r = '{kind: 1'b1, out_byte: 8'd0, patch_offset: size_pos,
                  patch_value: rec_size, last: 1'b0};
            item_outputs.push_back(r);
        end
    endfunction

    function automatic void open_header(input logic [15:0] id);
        push_byte(id[7:0]);
        push_byte(id[15:8]);
        size_pos = out_pos;
        hdr_size = (pred_left < {16'd0, rec_limit}) ? pred_left[15:0] : rec_limit;
        push_byte(hdr_size[7:0]);
        push_byte(hdr_size[15:8]);
        rec_size   = 16'd0;
        slice_fill = 32'd0;
    endfunction

    // Works out every output of one accepted item and queues them
    function automatic void frame_command(input cmd_item_t it);
        logic [31:0] len;
        out_item_t   r;
        item_outputs.delete();
        case (it.cmd)
            CMD_START:
            begin
                cont_limit = reg_max_record;
                rec_limit  = reg_max_record;
                pred_left  = it.predicted_size;
                in_rec     = 1'b1;
                open_header(it.record_id);
                slice_len  = 16'd0;
                slice_fill = 32'd0;
            end
            CMD_WRITE:
            begin
                len = {28'd0, (it.unit_bytes > UNIT_MAX_BYTES) ? UNIT_MAX_BYTES
                                                               : it.unit_bytes};
                if (in_rec)
                begin
                    // unit would overflow, or a fresh slice would not fit
                    if (({16'd0, rec_size} + len > {16'd0, rec_limit}) ||
                        (slice_len != 16'd0 && slice_fill == 32'd0 &&
                         {16'd0, rec_size} + {16'd0, slice_len} > {16'd0, rec_limit}))
                    begin
                        close_size();
                        rec_limit = cont_limit;
                        pred_left = pred_left - {16'd0, rec_size};
                        open_header(reg_cont_id);
                    end
                    rec_size = rec_size + len[15:0];
                    if (slice_len != 16'd0)
                    begin
                        slice_fill = slice_fill + len;
                        if (slice_fill >= {16'd0, slice_len})
                            slice_fill = 32'd0;
                    end
                end
                for (int i = 0; i < len; i++)
                    push_byte(it.unit_data[8*i +: 8]);
            end
            CMD_END:
            begin
                if (in_rec)
                begin
                    close_size();
                    in_rec = 1'b0;
                end
            end
            CMD_SLICE:
            begin
                slice_len  = it.slice_size;
                slice_fill = 32'd0;
            end
        endcase
        if (item_outputs.size() > 0)
        begin
            r = item_outputs.pop_back();
            r.last = 1'b1;
            item_outputs.push_back(r);
        end
        foreach (item_outputs[k])
            due_outputs.push_back(item_outputs[k]);
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stalls, long hold-off, and the field checks
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int gap;
        gap = 0;
        res_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                res_bus.ready <= 1'b0;
                hold_off = hold_off - 1;
            end
            else if (gap > 0)
            begin
                res_bus.ready <= 1'b0;
                gap = gap - 1;
            end
            else
            begin
                res_bus.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 9) == 0)
                    gap = $urandom_range(1, 10);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (due_outputs.size() == 0)
            begin
                $error("unexpected output item: kind %0d byte %0h", res_bus.kind,
                       res_bus.out_byte);
                errors++;
            end
            else
            begin
                want = due_outputs.pop_front();
                if (res_bus.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, res_bus.kind);
                    errors++;
                end
                if (res_bus.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte, res_bus.out_byte);
                    errors++;
                end
                if (res_bus.patch_offset !== want.patch_offset)
                begin
                    $error("patch_offset: expected %0d, got %0d", want.patch_offset,
                           res_bus.patch_offset);
                    errors++;
                end
                if (res_bus.patch_value !== want.patch_value)
                begin
                    $error("patch_value: expected %0d, got %0d", want.patch_value,
                           res_bus.patch_value);
                    errors++;
                end
                if (res_bus.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, res_bus.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[record_continuation_framer_unit] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side helpers
    // ------------------------------------------------------------------

    // All fields random, so unused fields toggle too; callers override what matters.
    function automatic cmd_item_t rand_item(input cmd_t c);
        cmd_item_t it;
        it.cmd            = c;
        it.record_id      = 16'($urandom());
        it.predicted_size = $urandom();
        it.unit_data      = {$urandom(), $urandom()};
        it.unit_bytes     = 4'($urandom_range(1, 8));
        it.slice_size     = 16'($urandom_range(0, 12));
        return it;
    endfunction

    // Called just after a rising edge; returns just after the accepting edge with valid high.
    task automatic send_item(input cmd_item_t it);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid          <= 1'b1;
        cmd_bus.cmd            <= it.cmd;
        cmd_bus.record_id      <= it.record_id;
        cmd_bus.predicted_size <= it.predicted_size;
        cmd_bus.unit_data      <= it.unit_data;
        cmd_bus.unit_bytes     <= it.unit_bytes;
        cmd_bus.slice_size     <= it.slice_size;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        frame_command(it);
        items_sent++;
    endtask

    // Stops offering and waits until every owed output has arrived.
    task automatic wait_drained();
        cmd_bus.valid <= 1'b0;
        @(posedge clk);
        while (due_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_registers(input logic [15:0] max_rec, input logic [15:0] cont_id);
        wait_drained();
        write_reg(CFG_MAX_RECORD, max_rec);
        write_reg(CFG_CONTINUE_ID, cont_id);
        reg_max_record = max_rec;
        reg_cont_id    = cont_id;
    endtask

    // A well-formed record with random content; now and then the end is left out,
    // so the next start drops the open record.
    task automatic send_record();
        cmd_item_t it;
        int        writes;
        it = rand_item(CMD_START);
        if ($urandom_range(0, 3) != 0)
            it.predicted_size = $urandom_range(0, 80);
        send_item(it);
        writes = $urandom_range(1, 10);
        repeat (writes)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                it = rand_item(CMD_SLICE);
                if ($urandom_range(0, 5) == 0)
                    it.slice_size = 16'($urandom());
                send_item(it);
            end
            it = rand_item(CMD_WRITE);
            case ($urandom_range(0, 11))
                0: it.unit_bytes = 4'd0;
                1: it.unit_bytes = 4'($urandom_range(9, 15));
                default: ;
            endcase
            send_item(it);
        end
        if ($urandom_range(0, 7) != 0)
            send_item(rand_item(CMD_END));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Outside a record: end ignored, units pass straight through, slice accepted
    task automatic test_passthrough();
        cmd_item_t it;
        send_item(rand_item(CMD_END));
        it = rand_item(CMD_WRITE);
        it.unit_bytes = 4'd0;
        send_item(it);
        it = rand_item(CMD_WRITE);
        it.unit_bytes = 4'd15;              // saturates to eight bytes
        it.unit_data  = '1;
        send_item(it);
        it = rand_item(CMD_SLICE);
        it.slice_size = 16'd5;
        send_item(it);
    endtask

    // Reset register values; actual size short of the prediction gives a patch
    task automatic test_defaults();
        cmd_item_t it;
        it = rand_item(CMD_START);
        it.record_id      = 16'h1234;
        it.predicted_size = 32'd12;
        send_item(it);
        it = rand_item(CMD_WRITE);
        it.unit_bytes = 4'd8;
        it.unit_data  = '0;
        send_item(it);
        it = rand_item(CMD_WRITE);
        it.unit_bytes = 4'd2;
        send_item(it);
        send_item(rand_item(CMD_END));
    endtask

    // Field extremes, and a start inside an open record
    task automatic test_extremes();
        cmd_item_t it;
        set_registers(16'hFFFF, 16'hFFFF);
        it = rand_item(CMD_START);
        it.record_id      = 16'hFFFF;
        it.predicted_size = 32'hFFFF_FFFF;
        send_item(it);
        it = rand_item(CMD_START);
        it.record_id      = 16'h0000;
        it.predicted_size = 32'd0;
        send_item(it);
        it = rand_item(CMD_WRITE);
        it.unit_bytes = 4'd8;
        send_item(it);
        send_item(rand_item(CMD_END));
    endtask

    // Overflowing units open continuations; the remainder wraps below zero
    task automatic test_continuation();
        cmd_item_t it;
        set_registers(16'd4, 16'd0);
        it = rand_item(CMD_START);
        it.predicted_size = 32'd3;
        send_item(it);
        it = rand_item(CMD_WRITE);
        it.unit_bytes = 4'd3;
        send_item(it);
        it.unit_bytes = 4'd2;
        send_item(it);
        it.unit_bytes = 4'd4;
        send_item(it);
        send_item(rand_item(CMD_END));
    endtask

    // Slices that must not be split, up to the widest slice; left open on purpose
    task automatic test_slices();
        cmd_item_t it;
        set_registers(16'd10, 16'h5A5A);
        it = rand_item(CMD_START);
        it.predicted_size = 32'd100;
        send_item(it);
        it = rand_item(CMD_SLICE);
        it.slice_size = 16'd4;
        send_item(it);
        it = rand_item(CMD_WRITE);
        it.unit_bytes = 4'd3;
        send_item(it);
        send_item(it);
        it = rand_item(CMD_SLICE);
        it.slice_size = 16'hFFFF;
        send_item(it);
        it = rand_item(CMD_WRITE);
        it.unit_bytes = 4'd1;
        send_item(it);
    endtask

    // Zero record limit: every sized write opens a continuation first
    task automatic test_zero_limit();
        cmd_item_t it;
        set_registers(16'd0, 16'h00C3);
        send_item(rand_item(CMD_START));
        it = rand_item(CMD_WRITE);
        it.unit_bytes = 4'd0;
        send_item(it);
        it.unit_bytes = 4'd2;
        send_item(it);
        send_item(it);
        send_item(rand_item(CMD_END));
    endtask

    // Phases of random registers; mostly well-formed records, some noise
    task automatic test_random(input int target);
        logic [15:0] lim;
        while (items_sent < target)
        begin
            case ($urandom_range(0, 7))
                0: lim = 16'hFFFF;
                1: lim = 16'($urandom());
                2: lim = 16'd1;
                3: lim = 16'd0;
                default: lim = 16'($urandom_range(2, 40));
            endcase
            set_registers(lim, 16'($urandom()));
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (4)
            begin
                if ($urandom_range(0, 5) == 0)
                    send_item(rand_item(cmd_t'($urandom_range(0, 3))));
                else
                    send_record();
            end
        end
        idle_on = 1'b1;
    endtask

    // Receiver holds off while items keep coming, so the block backs up
    task automatic test_backpressure();
        cmd_item_t it;
        set_registers(16'd6, 16'($urandom()));
        hold_off = 300;
        it = rand_item(CMD_START);
        it.predicted_size = 32'd50;
        send_item(it);
        repeat (18)
        begin
            it = rand_item(CMD_WRITE);
            it.unit_bytes = 4'd8;
            send_item(it);
        end
        send_item(rand_item(CMD_END));
        wait_drained();
    endtask

    // Last part of the run: no idling on either side
    task automatic test_burst();
        set_registers(16'd12, 16'($urandom()));
        idle_on = 1'b0;
        repeat (4) send_record();
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = CFG_MAX_RECORD;
        cfg_data               = 16'd0;
        cmd_bus.valid          = 1'b0;
        cmd_bus.cmd            = CMD_START;
        cmd_bus.record_id      = 16'd0;
        cmd_bus.predicted_size = 32'd0;
        cmd_bus.unit_data      = 64'd0;
        cmd_bus.unit_bytes     = 4'd0;
        cmd_bus.slice_size     = 16'd0;

        // model state after reset
        reg_max_record = MAX_RECORD_RESET;
        reg_cont_id    = CONTINUE_ID_RESET;
        in_rec         = 1'b0;
        rec_size       = 16'd0;
        rec_limit      = 16'd0;
        cont_limit     = MAX_RECORD_RESET;
        slice_len      = 16'd0;
        slice_fill     = 32'd0;
        pred_left      = 32'd0;
        hdr_size       = 16'd0;
        size_pos       = 32'd0;
        out_pos        = 32'd0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on = 1'b1;

        test_passthrough();
        test_defaults();
        test_extremes();
        test_continuation();
        test_slices();
        test_zero_limit();
        test_random(250);
        test_backpressure();
        test_burst();

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("[record_continuation_framer_unit] OK");
        else
            $display("[record_continuation_framer_unit] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
design/rcf_pkg.sv
design/rcf_cmd_if.sv
design/rcf_res_if.sv
design/rcf_front.sv
design/rcf_queue.sv
design/rcf_back.sv
design/record_continuation_framer_unit.sv
bench/tb.sv
